### hdl/rcb_pkg.sv
// Package: word types, character constants, rotor wiring tables and modular helpers.
`timescale 1ns / 1ps
`default_nettype none

package rcb_pkg;

    localparam int unsigned ALPHA_SIZE = 26;

    typedef logic [4:0] t_letter;
    typedef logic [2:0] t_cfg_idx;

    // register indexes on the config port
    localparam t_cfg_idx CFG_START_ONE   = 3'd0;
    localparam t_cfg_idx CFG_START_TWO   = 3'd1;
    localparam t_cfg_idx CFG_START_THREE = 3'd2;
    localparam t_cfg_idx CFG_DECRYPT     = 3'd3;

    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_LOWER_Z = 8'd122;

    localparam t_letter LETTER_LAST = 5'd25;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       restart;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       was_letter;
    } t_out_word;

    typedef struct packed {
        logic    is_letter;
        t_letter letter;
    } t_fold;

    typedef struct packed {
        t_letter rotor_one;
        t_letter rotor_two;
        t_letter rotor_three;
        logic    decrypt;
    } t_keys;

    // 26..31 fold back into the alphabet
    function automatic t_letter reduce_key(input t_letter v);
        return (v >= t_letter'(ALPHA_SIZE)) ? t_letter'(v - t_letter'(ALPHA_SIZE)) : v;
    endfunction

    // (x - off) mod 26, both operands already reduced
    function automatic t_letter mod_sub(input t_letter x, input t_letter off);
        logic [5:0] d;
        d = {1'b0, x} + 6'(ALPHA_SIZE) - {1'b0, off};
        return (d >= 6'(ALPHA_SIZE)) ? t_letter'(d - 6'(ALPHA_SIZE)) : d[4:0];
    endfunction

    // (x + off) mod 26
    function automatic t_letter mod_add(input t_letter x, input t_letter off);
        logic [5:0] s;
        s = {1'b0, x} + {1'b0, off};
        return (s >= 6'(ALPHA_SIZE)) ? t_letter'(s - 6'(ALPHA_SIZE)) : s[4:0];
    endfunction

    function automatic t_letter step_letter(input t_letter v);
        return (v == LETTER_LAST) ? t_letter'(0) : t_letter'(v + t_letter'(1));
    endfunction

    // rotor I: EKMFLGDQVZNTOWYHXUSPAIBRCJ
    function automatic t_letter fwd_one(input t_letter i);
        t_letter r;
        unique case (i)
            5'd0:  r = 5'd4;   5'd1:  r = 5'd10;  5'd2:  r = 5'd12;  5'd3:  r = 5'd5;
            5'd4:  r = 5'd11;  5'd5:  r = 5'd6;   5'd6:  r = 5'd3;   5'd7:  r = 5'd16;
            5'd8:  r = 5'd21;  5'd9:  r = 5'd25;  5'd10: r = 5'd13;  5'd11: r = 5'd19;
            5'd12: r = 5'd14;  5'd13: r = 5'd22;  5'd14: r = 5'd24;  5'd15: r = 5'd7;
            5'd16: r = 5'd23;  5'd17: r = 5'd20;  5'd18: r = 5'd18;  5'd19: r = 5'd15;
            5'd20: r = 5'd0;   5'd21: r = 5'd8;   5'd22: r = 5'd1;   5'd23: r = 5'd17;
            5'd24: r = 5'd2;   5'd25: r = 5'd9;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic t_letter inv_one(input t_letter i);
        t_letter r;
        unique case (i)
            5'd0:  r = 5'd20;  5'd1:  r = 5'd22;  5'd2:  r = 5'd24;  5'd3:  r = 5'd6;
            5'd4:  r = 5'd0;   5'd5:  r = 5'd3;   5'd6:  r = 5'd5;   5'd7:  r = 5'd15;
            5'd8:  r = 5'd21;  5'd9:  r = 5'd25;  5'd10: r = 5'd1;   5'd11: r = 5'd4;
            5'd12: r = 5'd2;   5'd13: r = 5'd10;  5'd14: r = 5'd12;  5'd15: r = 5'd19;
            5'd16: r = 5'd7;   5'd17: r = 5'd23;  5'd18: r = 5'd18;  5'd19: r = 5'd11;
            5'd20: r = 5'd17;  5'd21: r = 5'd8;   5'd22: r = 5'd13;  5'd23: r = 5'd16;
            5'd24: r = 5'd14;  5'd25: r = 5'd9;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // rotor II: AJDKSIRUXBLHWTMCQGZNPYFVOE
    function automatic t_letter fwd_two(input t_letter i);
        t_letter r;
        unique case (i)
            5'd0:  r = 5'd0;   5'd1:  r = 5'd9;   5'd2:  r = 5'd3;   5'd3:  r = 5'd10;
            5'd4:  r = 5'd18;  5'd5:  r = 5'd8;   5'd6:  r = 5'd17;  5'd7:  r = 5'd20;
            5'd8:  r = 5'd23;  5'd9:  r = 5'd1;   5'd10: r = 5'd11;  5'd11: r = 5'd7;
            5'd12: r = 5'd22;  5'd13: r = 5'd19;  5'd14: r = 5'd12;  5'd15: r = 5'd2;
            5'd16: r = 5'd16;  5'd17: r = 5'd6;   5'd18: r = 5'd25;  5'd19: r = 5'd13;
            5'd20: r = 5'd15;  5'd21: r = 5'd24;  5'd22: r = 5'd5;   5'd23: r = 5'd21;
            5'd24: r = 5'd14;  5'd25: r = 5'd4;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic t_letter inv_two(input t_letter i);
        t_letter r;
        unique case (i)
            5'd0:  r = 5'd0;   5'd1:  r = 5'd9;   5'd2:  r = 5'd15;  5'd3:  r = 5'd2;
            5'd4:  r = 5'd25;  5'd5:  r = 5'd22;  5'd6:  r = 5'd17;  5'd7:  r = 5'd11;
            5'd8:  r = 5'd5;   5'd9:  r = 5'd1;   5'd10: r = 5'd3;   5'd11: r = 5'd10;
            5'd12: r = 5'd14;  5'd13: r = 5'd19;  5'd14: r = 5'd24;  5'd15: r = 5'd20;
            5'd16: r = 5'd16;  5'd17: r = 5'd6;   5'd18: r = 5'd4;   5'd19: r = 5'd13;
            5'd20: r = 5'd7;   5'd21: r = 5'd23;  5'd22: r = 5'd12;  5'd23: r = 5'd8;
            5'd24: r = 5'd21;  5'd25: r = 5'd18;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // reflector B: YRUHQSLDPXNGOKMIEBFZCWVJAT, an involution, so it is its own inverse
    function automatic t_letter wire_three(input t_letter i);
        t_letter r;
        unique case (i)
            5'd0:  r = 5'd24;  5'd1:  r = 5'd17;  5'd2:  r = 5'd20;  5'd3:  r = 5'd7;
            5'd4:  r = 5'd16;  5'd5:  r = 5'd18;  5'd6:  r = 5'd11;  5'd7:  r = 5'd3;
            5'd8:  r = 5'd15;  5'd9:  r = 5'd23;  5'd10: r = 5'd13;  5'd11: r = 5'd6;
            5'd12: r = 5'd14;  5'd13: r = 5'd10;  5'd14: r = 5'd12;  5'd15: r = 5'd8;
            5'd16: r = 5'd4;   5'd17: r = 5'd1;   5'd18: r = 5'd5;   5'd19: r = 5'd25;
            5'd20: r = 5'd2;   5'd21: r = 5'd22;  5'd22: r = 5'd21;  5'd23: r = 5'd9;
            5'd24: r = 5'd0;   5'd25: r = 5'd19;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/rotor_cipher_byte_stream.sv
// Top level: rotor cipher over a byte stream, input register, one pass, result register.
// Throughput: one byte per cycle while the output is not stalled; the cycle holds the fold and the
// five wiring lookups with their mod-26 offset subtracts and adds, then the offset step.
// Reset (synchronous, active low) empties both stages, zeroes the config
// registers, both rotor offsets and the letter count. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module rotor_cipher_byte_stream (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // byte input
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire rcb_pkg::t_in_word   i_in_data,
    // cipher output
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output rcb_pkg::t_out_word       o_out_data,
    // config writes
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire rcb_pkg::t_cfg_idx   i_cfg_index,
    input  wire logic [7:0]          i_cfg_data
);

    // config registers, stored unreduced as written
    rcb_pkg::t_letter r_start_one, r_start_two, r_start_three;
    logic             r_decrypt;

    // rotor state
    rcb_pkg::t_letter r_rotor_one, r_rotor_two, r_count;
    rcb_pkg::t_letter n_rotor_one, n_rotor_two, n_count;

    // stage 1: registered input word
    logic              r_s1_valid;
    rcb_pkg::t_in_word r_s1_data;

    // stage 2: result register
    logic               r_out_valid;
    rcb_pkg::t_out_word r_out_data;
    rcb_pkg::t_out_word n_out_data;

    logic             w_advance;
    logic             w_accept;
    rcb_pkg::t_fold   w_fold;
    rcb_pkg::t_keys   w_keys;
    rcb_pkg::t_letter w_count;
    rcb_pkg::t_letter w_cipher;

    // config port never pushes back; writes must only land while idle, which the block does not enforce
    assign o_cfg_ready = 1'b1;

    // stage 1 moves on whenever the result register is free or being emptied
    assign w_advance  = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // restart reloads the offsets before this word is ciphered
    always_comb begin
        if (r_s1_data.restart) begin
            w_keys.rotor_one = rcb_pkg::reduce_key(r_start_one);
            w_keys.rotor_two = rcb_pkg::reduce_key(r_start_two);
            w_count          = '0;
        end else begin
            w_keys.rotor_one = r_rotor_one;
            w_keys.rotor_two = r_rotor_two;
            w_count          = r_count;
        end
        w_keys.rotor_three = rcb_pkg::reduce_key(r_start_three);
        w_keys.decrypt     = r_decrypt;
    end

    rcb_fold u_fold (
        .i_byte (r_s1_data.in_byte),
        .o_fold (w_fold)
    );

    rcb_path u_path (
        .i_letter (w_fold.letter),
        .i_keys   (w_keys),
        .o_letter (w_cipher)
    );

    // result word; non-letters go out as the raw byte
    always_comb begin
        if (w_fold.is_letter) begin
            n_out_data.out_byte   = rcb_pkg::CHAR_UPPER_A + {3'b000, w_cipher};
            n_out_data.was_letter = 1'b1;
        end else begin
            n_out_data.out_byte   = r_s1_data.in_byte;
            n_out_data.was_letter = 1'b0;
        end
    end

    // offset stepping: first rotor every letter, second rotor when the count wraps
    always_comb begin
        n_rotor_one = r_rotor_one;
        n_rotor_two = r_rotor_two;
        n_count     = r_count;
        if (w_advance) begin
            n_rotor_one = w_keys.rotor_one;
            n_rotor_two = w_keys.rotor_two;
            n_count     = w_count;
            if (w_fold.is_letter) begin
                n_rotor_one = rcb_pkg::step_letter(w_keys.rotor_one);
                n_count     = rcb_pkg::step_letter(w_count);
                if (w_count == rcb_pkg::LETTER_LAST) begin
                    n_rotor_two = rcb_pkg::step_letter(w_keys.rotor_two);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_one   <= '0;
            r_start_two   <= '0;
            r_start_three <= '0;
            r_decrypt     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rcb_pkg::CFG_START_ONE:   r_start_one   <= i_cfg_data[4:0];
                rcb_pkg::CFG_START_TWO:   r_start_two   <= i_cfg_data[4:0];
                rcb_pkg::CFG_START_THREE: r_start_three <= i_cfg_data[4:0];
                rcb_pkg::CFG_DECRYPT:     r_decrypt     <= i_cfg_data[0];
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rotor_one <= '0;
            r_rotor_two <= '0;
            r_count     <= '0;
        end else begin
            r_rotor_one <= n_rotor_one;
            r_rotor_two <= n_rotor_two;
            r_count     <= n_count;
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_data <= i_in_data;
        end
        if (w_advance) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire

### hdl/rcb_fold.sv
// Case fold of one CP1250 byte to a letter index A-Z, or not a letter.
`timescale 1ns / 1ps
`default_nettype none

module rcb_fold (
    input  wire logic [7:0]    i_byte,
    output rcb_pkg::t_fold     o_fold
);

    always_comb begin
        o_fold.is_letter = 1'b1;
        o_fold.letter    = '0;
        if (i_byte >= rcb_pkg::CHAR_UPPER_A && i_byte <= rcb_pkg::CHAR_UPPER_Z) begin
            o_fold.letter = 5'(i_byte - rcb_pkg::CHAR_UPPER_A);
        end else if (i_byte >= rcb_pkg::CHAR_LOWER_A && i_byte <= rcb_pkg::CHAR_LOWER_Z) begin
            o_fold.letter = 5'(i_byte - rcb_pkg::CHAR_LOWER_A);
        end else begin
            // Polish diacritics fold to their base letter
            unique case (i_byte)
                8'd185, 8'd165:                 o_fold.letter = 5'd0;   // A
                8'd230, 8'd198:                 o_fold.letter = 5'd2;   // C
                8'd234, 8'd202:                 o_fold.letter = 5'd4;   // E
                8'd179, 8'd163:                 o_fold.letter = 5'd11;  // L
                8'd241, 8'd209:                 o_fold.letter = 5'd13;  // N
                8'd243, 8'd211:                 o_fold.letter = 5'd14;  // O
                8'd156, 8'd140:                 o_fold.letter = 5'd18;  // S
                8'd191, 8'd175, 8'd159, 8'd143: o_fold.letter = 5'd25;  // Z
                default:                        o_fold.is_letter = 1'b0;
            endcase
        end
    end

endmodule

`default_nettype wire

### hdl/rcb_path.sv
// Five-wiring substitution path for one letter under the current offsets.
`timescale 1ns / 1ps
`default_nettype none

module rcb_path (
    input  wire rcb_pkg::t_letter i_letter,
    input  wire rcb_pkg::t_keys   i_keys,
    output rcb_pkg::t_letter      o_letter
);

    rcb_pkg::t_letter s1, s2, s3, s4;

    always_comb begin
        s1 = rcb_pkg::fwd_one(rcb_pkg::mod_sub(i_letter, i_keys.rotor_one));
        s2 = rcb_pkg::fwd_two(rcb_pkg::mod_sub(s1, i_keys.rotor_two));
        if (i_keys.decrypt) begin
            s3 = rcb_pkg::mod_add(rcb_pkg::wire_three(s2), i_keys.rotor_three);
        end else begin
            s3 = rcb_pkg::wire_three(rcb_pkg::mod_sub(s2, i_keys.rotor_three));
        end
        s4       = rcb_pkg::mod_add(rcb_pkg::inv_two(s3), i_keys.rotor_two);
        o_letter = rcb_pkg::mod_add(rcb_pkg::inv_one(s4), i_keys.rotor_one);
    end

endmodule

`default_nettype wire

### hdl/rcb_checker.sv
// Port-level checker for the rotor cipher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rcb_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire rcb_pkg::t_out_word o_out_data
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed while stalled");

    // input only backs up when the output side is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with room downstream");

    // ciphered words are always uppercase letters
    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.was_letter |->
            o_out_data.out_byte >= rcb_pkg::CHAR_UPPER_A &&
            o_out_data.out_byte <= rcb_pkg::CHAR_UPPER_Z)
        else $error("ciphered word outside A-Z");

    // passed-through bytes can never be plain ASCII letters
    a_pass_not_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.was_letter |->
            !(o_out_data.out_byte >= rcb_pkg::CHAR_UPPER_A &&
              o_out_data.out_byte <= rcb_pkg::CHAR_UPPER_Z) &&
            !(o_out_data.out_byte >= rcb_pkg::CHAR_LOWER_A &&
              o_out_data.out_byte <= rcb_pkg::CHAR_LOWER_Z))
        else $error("letter passed through unciphered");

    // nothing offered straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind rotor_cipher_byte_stream rcb_checker u_rcb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
